// ===== hw/rtl/srsp_pkg.sv =====
// Shared types and constants for the sound register stream player.
`timescale 1ns / 1ps
package srsp_pkg;

	localparam logic [2:0] KIND_BYTE = 3'd0;
	localparam logic [2:0] KIND_TICK = 3'd1;
	localparam logic [2:0] KIND_PLAY = 3'd2;
	localparam logic [2:0] KIND_FADE = 3'd3;
	localparam logic [2:0] KIND_STOP = 3'd4;

	localparam logic [1:0] OUT_WRITE   = 2'd0;
	localparam logic [1:0] OUT_SEEK    = 2'd1;
	localparam logic [1:0] OUT_FRAME   = 2'd2;
	localparam logic [1:0] OUT_STOPPED = 2'd3;

	localparam logic [7:0] VOL_REG   = 8'h80;
	localparam logic [7:0] VOL_RESET = 8'h77;
	localparam logic [7:0] BYTE_END  = 8'h00;
	localparam logic [7:0] BYTE_LOOP = 8'hFF;

	localparam int STOP_LEN = 13;
	localparam int STOP_IDX_W = $clog2(STOP_LEN + 1);

	localparam logic [7:0] STOP_ADDR [STOP_LEN] = '{
		8'h84, 8'h62, 8'h63, 8'h68, 8'h69, 8'h72, 8'h78,
		8'h79, 8'h65, 8'h6D, 8'h7D, 8'h70, 8'h80
	};
	localparam logic [7:0] STOP_VAL [STOP_LEN] = '{
		8'h8F, 8'h00, 8'h08, 8'h00, 8'h08, 8'h00, 8'h00,
		8'h08, 8'h80, 8'h80, 8'h80, 8'h00, 8'h77
	};

	localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h53, 8'h47, 8'h00};

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_SEEK,
		CMD_FRAME,
		CMD_STOP
	} cmd_op_t;

	// vol_pre: a master volume write of value precedes the main action
	typedef struct packed {
		cmd_op_t     op;
		logic        vol_pre;
		logic [7:0]  addr;
		logic [7:0]  value;
		logic [31:0] offset;
	} cmd_t;

endpackage

// ===== hw/rtl/srsp_front.sv =====
// Front end: stream parser and player state, one command per transfer at most.
`timescale 1ns / 1ps
module srsp_front #(
	parameter int OFFSET_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [2:0]     kind,
	input  logic [7:0]     byte_value,
	output logic           cmd_valid,
	output srsp_pkg::cmd_t cmd
);
	import srsp_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_WAIT   = 3'd2;
	localparam logic [2:0] PH_ADDR   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_LOOP   = 3'd5;

	localparam logic [1:0] HIDX_LAST = 2'(OFFSET_BYTES - 1);

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  hidx_q, hidx_d;
	logic [7:0]  pend_addr_q, pend_addr_d;
	logic [31:0] accum_q, accum_d;
	logic        fading_q, fading_d;
	logic [3:0]  fade_cnt_q, fade_cnt_d;
	logic [7:0]  vol_q, vol_d;

	logic [31:0] accum_next;
	logic [3:0]  fade_inc;
	logic [2:0]  vol_r, vol_l;
	logic [7:0]  vol_new;
	logic        stop_fx;

	assign accum_next = accum_q | (32'(byte_value) << {hidx_q, 3'b000});
	assign fade_inc   = fade_cnt_q + 4'd1;
	assign vol_r      = (vol_q[2:0] != 3'd0) ? vol_q[2:0] - 3'd1 : 3'd0;
	assign vol_l      = (vol_q[6:4] != 3'd0) ? vol_q[6:4] - 3'd1 : 3'd0;
	assign vol_new    = {1'b0, vol_l, 1'b0, vol_r};

	always_comb begin
		phase_d     = phase_q;
		hidx_d      = hidx_q;
		pend_addr_d = pend_addr_q;
		accum_d     = accum_q;
		fading_d    = fading_q;
		fade_cnt_d  = fade_cnt_q;
		vol_d       = vol_q;
		stop_fx     = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '{op: CMD_WRITE, vol_pre: 1'b0, addr: 8'h00, value: 8'h00,
			offset: 32'h0};
		unique case (kind) inside
			KIND_BYTE: begin
				unique case (phase_q)
					PH_HEADER: begin
						if (byte_value != MAGIC[hidx_q]) begin
							phase_d = PH_IDLE;
							hidx_d  = 2'd0;
						end else if (hidx_q == 2'd3) begin
							phase_d = PH_WAIT;
							hidx_d  = 2'd0;
						end else begin
							hidx_d = hidx_q + 2'd1;
						end
					end
					PH_ADDR: begin
						if (byte_value == BYTE_END) begin
							phase_d   = PH_WAIT;
							cmd_valid = 1'b1;
							cmd.op    = CMD_FRAME;
							if (fading_q) begin
								fade_cnt_d = fade_inc;
								if (fade_inc == 4'd0) begin
									vol_d       = vol_new;
									cmd.vol_pre = 1'b1;
									cmd.value   = vol_new;
									if (vol_new == 8'h00) begin
										cmd.op  = CMD_STOP;
										stop_fx = 1'b1;
									end
								end
							end
						end else if (byte_value == BYTE_LOOP) begin
							phase_d = PH_LOOP;
							hidx_d  = 2'd0;
							accum_d = 32'h0;
						end else begin
							pend_addr_d = byte_value;
							phase_d     = PH_DATA;
						end
					end
					PH_DATA: begin
						phase_d = PH_ADDR;
						if (!(fading_q && pend_addr_q == VOL_REG)) begin
							if (pend_addr_q == VOL_REG)
								vol_d = byte_value;
							cmd_valid = 1'b1;
							cmd.op    = CMD_WRITE;
							cmd.addr  = pend_addr_q;
							cmd.value = byte_value;
						end
					end
					PH_LOOP: begin
						accum_d = accum_next;
						if (hidx_q == HIDX_LAST) begin
							hidx_d    = 2'd0;
							cmd_valid = 1'b1;
							if (accum_next != 32'h0) begin
								phase_d    = PH_ADDR;
								cmd.op     = CMD_SEEK;
								cmd.offset = accum_next;
							end else begin
								cmd.op  = CMD_STOP;
								stop_fx = 1'b1;
							end
						end else begin
							hidx_d = hidx_q + 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_TICK: begin
				if (phase_q == PH_WAIT)
					phase_d = PH_ADDR;
			end
			KIND_PLAY, KIND_STOP: begin
				cmd_valid = 1'b1;
				cmd.op    = CMD_STOP;
				stop_fx   = 1'b1;
			end
			KIND_FADE: begin
				if (!fading_q) begin
					fading_d   = 1'b1;
					fade_cnt_d = 4'd1;
				end
			end
			default: begin
			end
		endcase
		if (stop_fx) begin
			phase_d    = PH_IDLE;
			hidx_d     = 2'd0;
			fading_d   = 1'b0;
			fade_cnt_d = 4'd0;
			vol_d      = VOL_RESET;
		end
		if (kind == KIND_PLAY)
			phase_d = PH_HEADER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hidx_q      <= 2'd0;
			pend_addr_q <= 8'h00;
			accum_q     <= 32'h0;
			fading_q    <= 1'b0;
			fade_cnt_q  <= 4'd0;
			vol_q       <= VOL_RESET;
		end else if (in_valid) begin
			phase_q     <= phase_d;
			hidx_q      <= hidx_d;
			pend_addr_q <= pend_addr_d;
			accum_q     <= accum_d;
			fading_q    <= fading_d;
			fade_cnt_q  <= fade_cnt_d;
			vol_q       <= vol_d;
		end
	end

endmodule

// ===== hw/rtl/srsp_cmd_queue.sv =====
// Small command queue between the parser and the result sequencer.
`timescale 1ns / 1ps
module srsp_cmd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srsp_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output srsp_pkg::cmd_t head
);
	import srsp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== hw/rtl/srsp_back.sv =====
// Back end: expands queued commands into result transfers via an output register.
`timescale 1ns / 1ps
module srsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  srsp_pkg::cmd_t head,
	output logic           head_pop,
	output logic           empty,
	input  logic           pop,
	output logic [1:0]     out_kind,
	output logic [7:0]     reg_addr,
	output logic [7:0]     reg_value,
	output logic [31:0]    seek_offset,
	output logic           last
);
	import srsp_pkg::*;

	logic [STOP_IDX_W-1:0] step_q;
	logic                  pre_done_q;
	logic                  valid_q;
	logic [1:0]            kind_q;
	logic [7:0]            addr_q, value_q;
	logic [31:0]           offset_q;
	logic                  last_q;

	logic                  load, fin, pre_now;
	logic [1:0]            r_kind;
	logic [7:0]            r_addr, r_value;
	logic [31:0]           r_offset;

	assign load     = head_valid && (!valid_q || pop);
	assign pre_now  = head.vol_pre && !pre_done_q;
	assign head_pop = load && fin;

	always_comb begin
		r_kind   = OUT_WRITE;
		r_addr   = 8'h00;
		r_value  = 8'h00;
		r_offset = 32'h0;
		fin      = 1'b0;
		if (pre_now) begin
			r_addr  = VOL_REG;
			r_value = head.value;
		end else begin
			unique case (head.op)
				CMD_WRITE: begin
					r_addr  = head.addr;
					r_value = head.value;
					fin     = 1'b1;
				end
				CMD_SEEK: begin
					r_kind   = OUT_SEEK;
					r_offset = head.offset;
					fin      = 1'b1;
				end
				CMD_FRAME: begin
					r_kind = OUT_FRAME;
					fin    = 1'b1;
				end
				CMD_STOP: begin
					if (step_q == STOP_IDX_W'(STOP_LEN)) begin
						r_kind = OUT_STOPPED;
						fin    = 1'b1;
					end else begin
						r_addr  = STOP_ADDR[step_q];
						r_value = STOP_VAL[step_q];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= r_kind;
			addr_q   <= r_addr;
			value_q  <= r_value;
			offset_q <= r_offset;
			last_q   <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			step_q     <= '0;
			pre_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (fin) begin
					step_q     <= '0;
					pre_done_q <= 1'b0;
				end else if (pre_now) begin
					pre_done_q <= 1'b1;
				end else begin
					step_q <= step_q + STOP_IDX_W'(1);
				end
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !valid_q;
	assign out_kind    = kind_q;
	assign reg_addr    = addr_q;
	assign reg_value   = value_q;
	assign seek_offset = offset_q;
	assign last        = last_q;

endmodule

// ===== hw/rtl/sound_register_stream_player.sv =====
// Sound register stream player: parser front end, command queue, result sequencer.
// Input commands are registered in the command queue, results in the output register.
// Throughput: one input per cycle while the queue has room; results drain at one per cycle
// while the receiver pops; a stop burst of 14 results (15 after a fade) holds the queue head.
// Reset clears parser state, the queue and the output valid flag; volume shadow is 0x77.
`timescale 1ns / 1ps
module sound_register_stream_player #(
	parameter int OFFSET_BYTES = 4,
	parameter int CMD_DEPTH    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_kind,
	output logic [7:0]  reg_addr,
	output logic [7:0]  reg_value,
	output logic [31:0] seek_offset,
	output logic        last
);
	import srsp_pkg::*;

	logic in_xfer;
	logic cmd_valid;
	cmd_t cmd;
	logic head_valid;
	cmd_t head;
	logic head_pop;

	assign in_xfer = push && !full;

	srsp_front #(
		.OFFSET_BYTES(OFFSET_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_xfer),
		.kind      (kind),
		.byte_value(byte_value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	srsp_cmd_queue #(
		.DEPTH(CMD_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_xfer && cmd_valid),
		.push_data (cmd),
		.full      (full),
		.pop       (head_pop),
		.head_valid(head_valid),
		.head      (head)
	);

	srsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_kind   (out_kind),
		.reg_addr   (reg_addr),
		.reg_value  (reg_value),
		.seek_offset(seek_offset),
		.last       (last)
	);

endmodule

// ===== tb/srsp_checker.sv =====
// Checker for the sound register stream player: tracks player state and compares every result.
`timescale 1ns / 1ps
module srsp_checker #(
	parameter int OFFSET_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  reg_value,
	input  logic [31:0] seek_offset,
	input  logic        last,
	output int          errors,
	output int          outstanding,
	output int          checked,
	output int          stops
);
	import srsp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEADER,
		ST_WAIT,
		ST_ADDR,
		ST_DATA,
		ST_LOOP
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  addr;
		logic [7:0]  value;
		logic [31:0] offset;
		logic        last;
	} player_out_t;

	localparam logic [7:0] SILENCE_ADDR [13] = '{
		8'h84, 8'h62, 8'h63, 8'h68, 8'h69, 8'h72, 8'h78,
		8'h79, 8'h65, 8'h6D, 8'h7D, 8'h70, 8'h80
	};
	localparam logic [7:0] SILENCE_VAL [13] = '{
		8'h8F, 8'h00, 8'h08, 8'h00, 8'h08, 8'h00, 8'h00,
		8'h08, 8'h80, 8'h80, 8'h80, 8'h00, 8'h77
	};
	localparam logic [7:0] HEADER_TAG [4] = '{8'h50, 8'h53, 8'h47, 8'h00};

	parse_state_t pstate;
	logic         in_play;
	logic [1:0]   tag_pos;
	logic [7:0]   held_addr;
	logic [31:0]  loop_acc;
	logic         fading;
	logic [3:0]   fade_cnt;
	logic [7:0]   vol_shadow;

	player_out_t  awaited [$];
	player_out_t  burst [$];

	task automatic note(input logic [1:0] k, input logic [7:0] a, input logic [7:0] v,
			input logic [31:0] off);
		player_out_t r;
		r.kind = k;
		r.addr = a;
		r.value = v;
		r.offset = off;
		r.last = 1'b0;
		burst.push_back(r);
	endtask

	task automatic silence();
		for (int i = 0; i < 13; i++)
			note(OUT_WRITE, SILENCE_ADDR[i], SILENCE_VAL[i], '0);
		note(OUT_STOPPED, '0, '0, '0);
		in_play = 1'b0;
		pstate = ST_IDLE;
		tag_pos = '0;
		fading = 1'b0;
		fade_cnt = '0;
		vol_shadow = VOL_RESET;
	endtask

	task automatic close_frame();
		logic [2:0] lo;
		logic [2:0] hi;
		logic       silent;
		silent = 1'b0;
		pstate = ST_WAIT;
		if (fading) begin
			fade_cnt = fade_cnt + 4'd1;
			if (fade_cnt == 4'd0) begin
				lo = vol_shadow[2:0];
				hi = vol_shadow[6:4];
				if (lo != 3'd0)
					lo = lo - 3'd1;
				if (hi != 3'd0)
					hi = hi - 3'd1;
				vol_shadow = {1'b0, hi, 1'b0, lo};
				note(OUT_WRITE, VOL_REG, vol_shadow, '0);
				silent = (lo == 3'd0) && (hi == 3'd0);
			end
		end
		if (silent)
			silence();
		else
			note(OUT_FRAME, '0, '0, '0);
	endtask

	task automatic take_byte(input logic [7:0] b);
		case (pstate)
			ST_HEADER: begin
				if (b != HEADER_TAG[tag_pos]) begin
					pstate = ST_IDLE;
					tag_pos = '0;
				end else if (tag_pos == 2'd3) begin
					pstate = ST_WAIT;
					tag_pos = '0;
					in_play = 1'b1;
				end else begin
					tag_pos = tag_pos + 2'd1;
				end
			end
			ST_ADDR: begin
				if (b == BYTE_END) begin
					close_frame();
				end else if (b == BYTE_LOOP) begin
					pstate = ST_LOOP;
					tag_pos = '0;
					loop_acc = '0;
				end else begin
					held_addr = b;
					pstate = ST_DATA;
				end
			end
			ST_DATA: begin
				pstate = ST_ADDR;
				// master volume writes are swallowed during a fade
				if (!(fading && held_addr == VOL_REG)) begin
					if (held_addr == VOL_REG)
						vol_shadow = b;
					note(OUT_WRITE, held_addr, b, '0);
				end
			end
			ST_LOOP: begin
				loop_acc = loop_acc | ({24'd0, b} << (8 * tag_pos));
				if (int'(tag_pos) + 1 >= OFFSET_BYTES) begin
					tag_pos = '0;
					if (loop_acc != '0) begin
						pstate = ST_ADDR;
						note(OUT_SEEK, '0, '0, loop_acc);
					end else begin
						silence();
					end
				end else begin
					tag_pos = tag_pos + 2'd1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic advance(input logic [2:0] k, input logic [7:0] b);
		player_out_t r;
		burst.delete();
		case (k)
			KIND_BYTE: take_byte(b);
			KIND_TICK: begin
				if (pstate == ST_WAIT)
					pstate = ST_ADDR;
			end
			KIND_PLAY: begin
				silence();
				pstate = ST_HEADER;
				tag_pos = '0;
			end
			KIND_FADE: begin
				if (!fading) begin
					fading = 1'b1;
					fade_cnt = 4'd1;
				end
			end
			KIND_STOP: silence();
			default: ;
		endcase
		if (burst.size() > 0) begin
			r = burst.pop_back();
			r.last = 1'b1;
			burst.push_back(r);
		end
		while (burst.size() > 0)
			awaited.push_back(burst.pop_front());
	endtask

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic compare();
		player_out_t want;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: expected none, got kind %0d addr %h value %h offset %h last %b",
				$time, out_kind, reg_addr, reg_value, seek_offset, last);
		end else begin
			want = awaited.pop_front();
			checked++;
			if (want.kind == OUT_STOPPED)
				stops++;
			field_check("out_kind", 32'(want.kind), 32'(out_kind));
			field_check("reg_addr", 32'(want.addr), 32'(reg_addr));
			field_check("reg_value", 32'(want.value), 32'(reg_value));
			field_check("seek_offset", want.offset, seek_offset);
			field_check("last", 32'(want.last), 32'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate = ST_IDLE;
			in_play = 1'b0;
			tag_pos = '0;
			held_addr = '0;
			loop_acc = '0;
			fading = 1'b0;
			fade_cnt = '0;
			vol_shadow = VOL_RESET;
			awaited.delete();
			errors = 0;
			checked = 0;
			stops = 0;
		end else begin
			if (push && !full)
				advance(kind, byte_value);
			if (pop && !empty)
				compare();
		end
		outstanding = awaited.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives play sessions and frame streams into the player, gives the verdict.
`timescale 1ns / 1ps
module testbench;
	import srsp_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;
	localparam int         ITEM_TARGET  = 380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [2:0]  kind = KIND_BYTE;
	logic [7:0]  byte_value = 8'h00;
	logic        full;
	logic        empty;
	logic [1:0]  out_kind;
	logic [7:0]  reg_addr;
	logic [7:0]  reg_value;
	logic [31:0] seek_offset;
	logic        last;

	int errors;
	int outstanding;
	int checked;
	int stops;

	int burst_left = 0;
	int sent = 0;
	int useful = 0;
	int rx_mode = 0;
	int rx_left = 0;

	always #6 clk = ~clk;

	sound_register_stream_player dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.byte_value(byte_value),
		.empty(empty),
		.pop(pop),
		.out_kind(out_kind),
		.reg_addr(reg_addr),
		.reg_value(reg_value),
		.seek_offset(seek_offset),
		.last(last)
	);

	srsp_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.byte_value(byte_value),
		.empty(empty),
		.pop(pop),
		.out_kind(out_kind),
		.reg_addr(reg_addr),
		.reg_value(reg_value),
		.seek_offset(seek_offset),
		.last(last),
		.errors(errors),
		.outstanding(outstanding),
		.checked(checked),
		.stops(stops)
	);

	// receiver: free-running, half-rate, sparse and mostly-ready spells
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			2: pop <= ($urandom_range(0, 1) != 0);
			default: pop <= (rx_left % 4 == 0);
		endcase
	end

	task automatic send(input logic [2:0] k, input logic [7:0] b, input bit counted = 1'b1);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		push <= 1'b1;
		kind <= k;
		byte_value <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
		sent++;
		if (counted)
			useful++;
	endtask

	task automatic put(input logic [7:0] b);
		send(KIND_BYTE, b);
	endtask

	task automatic start_playback(input bit may_corrupt);
		logic [7:0] tag [4];
		int         bad;
		tag = '{8'h50, 8'h53, 8'h47, 8'h00};
		bad = (may_corrupt && $urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : -1;
		send(KIND_PLAY, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 4; i++)
			put((i == bad) ? tag[i] ^ 8'($urandom_range(1, 255)) : tag[i]);
	endtask

	task automatic put_loop(input logic [31:0] off);
		put(BYTE_LOOP);
		for (int i = 0; i < 4; i++)
			put(off[8 * i +: 8]);
	endtask

	task automatic put_write(input logic [7:0] a, input logic [7:0] v);
		put(a);
		put(v);
	endtask

	task automatic random_pair();
		logic [7:0] a;
		a = ($urandom_range(0, 4) == 0) ? VOL_REG : 8'($urandom_range(1, 254));
		put_write(a, 8'($urandom_range(0, 255)));
	endtask

	task automatic session();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 9) == 0)
				put(8'($urandom_range(0, 255)));
			send(KIND_TICK, 8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 15))
					0: put_loop(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom());
					1: send(KIND_FADE, 8'($urandom_range(0, 255)));
					2: send(KIND_TICK, 8'($urandom_range(0, 255)));
					default: random_pair();
				endcase
			end
			put(BYTE_END);
			if ($urandom_range(0, 15) == 0)
				send(KIND_STOP, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic fade_session();
		start_playback(1'b0);
		send(KIND_TICK, 8'h00);
		put_write(VOL_REG, {1'b0, 3'($urandom_range(0, 2)), 1'b0, 3'($urandom_range(0, 2))});
		put(BYTE_END);
		send(KIND_FADE, 8'h00);
		repeat ($urandom_range(16, 40)) begin
			send(KIND_TICK, 8'h00);
			if ($urandom_range(0, 3) == 0)
				random_pair();
			put(BYTE_END);
		end
	endtask

	task automatic directed();
		send(KIND_SPARE_A, 8'hFF, 1'b0);
		send(KIND_SPARE_C, 8'h00, 1'b0);
		send(KIND_BYTE, 8'h50, 1'b0);
		start_playback(1'b0);
		put(8'h12);
		send(KIND_TICK, 8'h00);
		put_write(VOL_REG, 8'h00);
		put_loop(32'hFFFF_FFFF);
		put(BYTE_END);
		send(KIND_FADE, 8'h00);
		send(KIND_TICK, 8'h00);
		put_write(VOL_REG, 8'h55);
		put_loop(32'd0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		while (useful < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 4))
					send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
				7, 8: fade_session();
				default: begin
					start_playback(1'b1);
					session();
				end
			endcase
		end
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("Covered %0d input transfers and %0d result transfers checked,", sent, checked);
		$display("including %0d stop sequences from play, stop, loop end and fade-out.", stops);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
